/* rtl/lvf_pkg.sv */
package lvf_pkg;

   localparam int DATA_W      = 32;
   localparam int SCALE_W     = 31;
   localparam int DT_W        = 18;
   localparam int ACC_W       = 42;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SCALE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUPLING   = 2'd1;

   localparam logic [SCALE_W-1:0] CELL_SCALE_RESET = 31'd655360;
   // 2.0 in q16.16, the damp factor is (2 - dt) / 2
   localparam logic [DT_W:0]      DAMP_ONE         = 19'd131072;

   typedef enum logic [1:0] {
      MODE_READ     = 2'd0,
      MODE_ADD      = 2'd1,
      MODE_INTERACT = 2'd2,
      MODE_DAMP     = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MULX,
      F_MULY,
      F_MULZ,
      F_SUM,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_CLEAR,
      B_IDLE,
      B_CELL,
      B_MUL1,
      B_POST1,
      B_MUL2,
      B_POST2,
      B_MUL3,
      B_POST3,
      B_DREAD,
      B_DMUL,
      B_DPOST
   } back_state_type;

   typedef struct packed {
      mode_type                 mode;
      logic                     hit;
      logic signed [DATA_W-1:0] vec_x;
      logic signed [DATA_W-1:0] vec_y;
      logic signed [DATA_W-1:0] vec_z;
      logic [DT_W-1:0]          time_step;
   } job_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] field_x;
      logic signed [DATA_W-1:0] field_y;
      logic signed [DATA_W-1:0] field_z;
      logic signed [DATA_W-1:0] vel_x;
      logic signed [DATA_W-1:0] vel_y;
      logic signed [DATA_W-1:0] vel_z;
   } rsp_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] add_sat(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
      logic [DATA_W:0]          s;
      logic signed [DATA_W-1:0] r;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
         r = s[DATA_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = s[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/lattice_vector_field_engine.sv */
// channel   ports                               beat taken when
// -------   ---------------------------------   -------------------------
// request   req_push/req_full, req_* fields     req_push && !req_full
// response  rsp_empty/rsp_pop, rsp_* fields     rsp_pop && !rsp_empty
// csr       csr_we, csr_index, csr_wdata        csr_we
//
// front: one request beat at a time, through the shared position multiplier
//   (three products and the index sum); a two-entry queue feeds the back end
// back: a miss skips the cell ram, read/add use one cell read, interact does three
//   dependent multiplies per lane, damp rescales every cell; one cell ram port pair
// after reset every cell of the cell ram is zeroed with req_full high
// a response waiting on rsp_pop holds the back end; the front keeps filling the queue
module lattice_vector_field_engine #(
   parameter int GRID_SIDE = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic [17:0]        req_time_step,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_field_x,
   output logic signed [31:0] rsp_field_y,
   output logic signed [31:0] rsp_field_z,
   output logic signed [31:0] rsp_vel_x,
   output logic signed [31:0] rsp_vel_y,
   output logic signed [31:0] rsp_vel_z,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import lvf_pkg::*;

   localparam int CELLS = GRID_SIDE ** 3;
   localparam int IDX_W = $clog2(CELLS);
   localparam int Q_W   = $bits(job_type) + IDX_W;

   logic [SCALE_W-1:0]       cell_scale_ff, cell_scale_in;
   logic signed [DATA_W-1:0] coupling_ff, coupling_in;

   logic             front_ready, clearing, start;
   logic             fq_valid, fq_full;
   job_type          fq_job;
   logic [IDX_W-1:0] fq_idx;
   logic [Q_W-1:0]   q_dout;
   logic             q_empty, q_pop;
   job_type          q_job;
   logic [IDX_W-1:0] q_idx;
   logic             rsp_valid;
   rsp_type          rsp;

   always_comb begin
      cell_scale_in = cell_scale_ff;
      coupling_in   = coupling_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CELL_SCALE: cell_scale_in = csr_wdata[SCALE_W-1:0];
            CSR_COUPLING:   coupling_in   = csr_wdata;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_scale_ff <= CELL_SCALE_RESET;
         coupling_ff   <= '0;
      end else begin
         cell_scale_ff <= cell_scale_in;
         coupling_ff   <= coupling_in;
      end
   end

   assign req_full = !front_ready || clearing;
   assign start    = req_push && !req_full;

   lvf_front #(
      .GRID_SIDE (GRID_SIDE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .mode       (mode_type'(req_mode)),
      .pos_x      (req_pos_x),
      .pos_y      (req_pos_y),
      .pos_z      (req_pos_z),
      .vec_x      (req_vec_x),
      .vec_y      (req_vec_y),
      .vec_z      (req_vec_z),
      .time_step  (req_time_step),
      .cell_scale (cell_scale_ff),
      .ready      (front_ready),
      .job_valid  (fq_valid),
      .job_full   (fq_full),
      .job        (fq_job),
      .job_idx    (fq_idx)
   );

   lvf_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (fq_valid),
      .din   ({fq_job, fq_idx}),
      .full  (fq_full),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty)
   );

   assign q_job = q_dout[Q_W-1:IDX_W];
   assign q_idx = q_dout[IDX_W-1:0];

   lvf_back #(
      .GRID_SIDE (GRID_SIDE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (q_empty),
      .job       (q_job),
      .job_idx   (q_idx),
      .job_pop   (q_pop),
      .coupling  (coupling_ff),
      .clearing  (clearing),
      .rsp_pop   (rsp_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_empty   = !rsp_valid;
   assign rsp_hit     = rsp.hit;
   assign rsp_field_x = rsp.field_x;
   assign rsp_field_y = rsp.field_y;
   assign rsp_field_z = rsp.field_z;
   assign rsp_vel_x   = rsp.vel_x;
   assign rsp_vel_y   = rsp.vel_y;
   assign rsp_vel_z   = rsp.vel_z;

endmodule

/* rtl/lvf_ram.sv */
module lvf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lvf_front.sv */
module lvf_front #(
   parameter int GRID_SIDE = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  lvf_pkg::mode_type                   mode,
   input  logic signed [31:0]                  pos_x,
   input  logic signed [31:0]                  pos_y,
   input  logic signed [31:0]                  pos_z,
   input  logic signed [31:0]                  vec_x,
   input  logic signed [31:0]                  vec_y,
   input  logic signed [31:0]                  vec_z,
   input  logic [17:0]                         time_step,
   input  logic [30:0]                         cell_scale,
   output logic                                ready,
   output logic                                job_valid,
   input  logic                                job_full,
   output lvf_pkg::job_type                    job,
   output logic [$clog2(GRID_SIDE**3)-1:0]     job_idx
);
   import lvf_pkg::*;

   localparam int CELLS = GRID_SIDE ** 3;
   localparam int IDX_W = $clog2(CELLS);
   localparam logic signed [ACC_W-1:0] W_Y     = ACC_W'(GRID_SIDE);
   localparam logic signed [ACC_W-1:0] W_Z     = ACC_W'(GRID_SIDE * GRID_SIDE);
   localparam logic signed [ACC_W-1:0] CELLS_S = ACC_W'(CELLS);

   front_state_type state_ff, state_in;

   job_type                  job_ff;
   logic signed [DATA_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [DATA_W-1:0] mul_pos, scale_s, coord;
   logic signed [63:0]       prod_ff, prod_in, rounded;
   logic signed [ACC_W-1:0]  coord_ext, acc_ff, acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         job_ff.mode      <= mode;
         job_ff.hit       <= 1'b0;
         job_ff.vec_x     <= vec_x;
         job_ff.vec_y     <= vec_y;
         job_ff.vec_z     <= vec_z;
         job_ff.time_step <= time_step;
         pos_x_ff         <= pos_x;
         pos_y_ff         <= pos_y;
         pos_z_ff         <= pos_z;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // one shared position multiplier, three products in a row
   always_comb begin
      scale_s = {1'b0, cell_scale};
      case (state_ff)
         F_MULX:  mul_pos = pos_x_ff;
         F_MULY:  mul_pos = pos_y_ff;
         default: mul_pos = pos_z_ff;
      endcase
      prod_in = mul_pos * scale_s;

      // truncate q32.32 toward zero
      rounded   = prod_ff + (prod_ff[63] ? 64'sd4294967295 : 64'sd0);
      coord     = rounded[63:32];
      coord_ext = {{(ACC_W-DATA_W){coord[DATA_W-1]}}, coord};
   end

   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      ready     = 1'b0;
      job_valid = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            ready = 1'b1;
            if (start) begin
               state_in = F_MULX;
            end
         end
         F_MULX: begin
            state_in = F_MULY;
         end
         F_MULY: begin
            acc_in   = coord_ext;
            state_in = F_MULZ;
         end
         F_MULZ: begin
            acc_in   = acc_ff + coord_ext * W_Y;
            state_in = F_SUM;
         end
         F_SUM: begin
            acc_in   = acc_ff + coord_ext * W_Z;
            state_in = F_PUSH;
         end
         F_PUSH: begin
            job_valid = 1'b1;
            if (!job_full) begin
               ready    = 1'b1;
               state_in = start ? F_MULX : F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_comb begin
      job     = job_ff;
      job.hit = !acc_ff[ACC_W-1] && (acc_ff < CELLS_S);
      job_idx = acc_ff[IDX_W-1:0];
   end

endmodule

/* rtl/lvf_queue.sv */
module lvf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   always_comb begin
      full    = (count_ff == CNT_W'(DEPTH));
      empty   = (count_ff == '0);
      push_ok = push && !full;
      pop_ok  = pop && !empty;
      dout    = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

/* rtl/lvf_back.sv */
module lvf_back #(
   parameter int GRID_SIDE = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            job_empty,
   input  lvf_pkg::job_type                job,
   input  logic [$clog2(GRID_SIDE**3)-1:0] job_idx,
   output logic                            job_pop,
   input  logic signed [31:0]              coupling,
   output logic                            clearing,
   input  logic                            rsp_pop,
   output logic                            rsp_valid,
   output lvf_pkg::rsp_type                rsp
);
   import lvf_pkg::*;

   localparam int CELLS = GRID_SIDE ** 3;
   localparam int IDX_W = $clog2(CELLS);
   localparam int RAM_W = 3 * DATA_W;
   localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(CELLS - 1);

   back_state_type state_ff, state_in;

   logic [IDX_W-1:0]         addr_ff, addr_in;
   job_type                  cur_ff, cur_in;
   logic signed [DT_W:0]     factor_ff, factor_in;
   logic signed [DATA_W-1:0] f_ff [3];
   logic signed [DATA_W-1:0] f_in [3];
   logic signed [DATA_W-1:0] v_ff [3];
   logic signed [DATA_W-1:0] v_in [3];
   logic signed [DATA_W-1:0] t_ff [3];
   logic signed [DATA_W-1:0] t_in [3];
   logic signed [63:0]       prod_ff [3];
   logic signed [63:0]       prod_in [3];
   logic signed [DATA_W-1:0] mul_a [3];
   logic signed [DATA_W-1:0] mul_b;
   logic signed [DATA_W-1:0] rd_vec [3];
   logic signed [DATA_W-1:0] vin [3];
   logic signed [DATA_W-1:0] q16 [3];
   logic signed [DATA_W-1:0] damped [3];
   logic signed [DATA_W-1:0] added [3];
   logic signed [DATA_W-1:0] f_new [3];

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   logic [RAM_W-1:0] ram_wdata, ram_rdata;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    out_free;

   lvf_ram #(
      .WIDTH (RAM_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // lane datapath, one multiplier per vector component
   always_comb begin
      rd_vec[0] = ram_rdata[DATA_W-1:0];
      rd_vec[1] = ram_rdata[2*DATA_W-1:DATA_W];
      rd_vec[2] = ram_rdata[3*DATA_W-1:2*DATA_W];
      vin[0]    = cur_ff.vec_x;
      vin[1]    = cur_ff.vec_y;
      vin[2]    = cur_ff.vec_z;
      case (state_ff)
         B_MUL3:  mul_b = coupling;
         B_DMUL:  mul_b = {{(DATA_W-DT_W-1){factor_ff[DT_W]}}, factor_ff};
         default: mul_b = {{(DATA_W-DT_W){1'b0}}, cur_ff.time_step};
      endcase
      for (int i = 0; i < 3; i++) begin
         case (state_ff)
            B_MUL2:  mul_a[i] = v_ff[i];
            B_MUL3:  mul_a[i] = t_ff[i];
            default: mul_a[i] = f_ff[i];
         endcase
         prod_in[i] = mul_a[i] * mul_b;
         q16[i]     = sat32(prod_ff[i] >>> 16);
         damped[i]  = sat32(prod_ff[i] >>> 17);
         added[i]   = add_sat(rd_vec[i], vin[i]);
         f_new[i]   = add_sat(f_ff[i], q16[i]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      cur_in       = cur_ff;
      factor_in    = factor_ff;
      f_in         = f_ff;
      v_in         = v_ff;
      t_in         = t_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      out_free     = !rsp_valid_ff || rsp_pop;
      job_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = '0;
      ram_raddr    = addr_ff;

      unique case (state_ff)
         B_CLEAR: begin
            ram_we = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = B_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         B_IDLE: begin
            if (!job_empty && out_free) begin
               job_pop   = 1'b1;
               cur_in    = job;
               factor_in = DAMP_ONE - {1'b0, job.time_step};
               if (job.mode == MODE_DAMP) begin
                  addr_in   = '0;
                  ram_raddr = '0;
                  state_in  = B_DREAD;
               end else if (job.hit) begin
                  addr_in   = job_idx;
                  ram_raddr = job_idx;
                  state_in  = B_CELL;
               end else begin
                  // miss: interact echoes the velocity
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  if (job.mode == MODE_INTERACT) begin
                     rsp_in.vel_x = job.vec_x;
                     rsp_in.vel_y = job.vec_y;
                     rsp_in.vel_z = job.vec_z;
                  end
               end
            end
         end
         B_CELL: begin
            unique case (cur_ff.mode)
               MODE_READ: begin
                  rsp_valid_in   = 1'b1;
                  rsp_in         = '0;
                  rsp_in.hit     = 1'b1;
                  rsp_in.field_x = rd_vec[0];
                  rsp_in.field_y = rd_vec[1];
                  rsp_in.field_z = rd_vec[2];
                  state_in       = B_IDLE;
               end
               MODE_ADD: begin
                  ram_we         = 1'b1;
                  ram_wdata      = {added[2], added[1], added[0]};
                  rsp_valid_in   = 1'b1;
                  rsp_in         = '0;
                  rsp_in.hit     = 1'b1;
                  rsp_in.field_x = added[0];
                  rsp_in.field_y = added[1];
                  rsp_in.field_z = added[2];
                  state_in       = B_IDLE;
               end
               default: begin
                  f_in     = rd_vec;
                  state_in = B_MUL1;
               end
            endcase
         end
         B_MUL1: begin
            state_in = B_POST1;
         end
         B_POST1: begin
            for (int i = 0; i < 3; i++) begin
               v_in[i] = add_sat(vin[i], q16[i]);
            end
            state_in = B_MUL2;
         end
         B_MUL2: begin
            state_in = B_POST2;
         end
         B_POST2: begin
            t_in     = q16;
            state_in = B_MUL3;
         end
         B_MUL3: begin
            state_in = B_POST3;
         end
         B_POST3: begin
            ram_we         = 1'b1;
            ram_wdata      = {f_new[2], f_new[1], f_new[0]};
            rsp_valid_in   = 1'b1;
            rsp_in.hit     = 1'b1;
            rsp_in.field_x = f_new[0];
            rsp_in.field_y = f_new[1];
            rsp_in.field_z = f_new[2];
            rsp_in.vel_x   = v_ff[0];
            rsp_in.vel_y   = v_ff[1];
            rsp_in.vel_z   = v_ff[2];
            state_in       = B_IDLE;
         end
         B_DREAD: begin
            f_in     = rd_vec;
            state_in = B_DMUL;
         end
         B_DMUL: begin
            state_in = B_DPOST;
         end
         B_DPOST: begin
            ram_we    = 1'b1;
            ram_wdata = {damped[2], damped[1], damped[0]};
            if (addr_ff == LAST_ADDR) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = B_IDLE;
            end else begin
               // fetch the next cell while this one is written
               addr_in   = addr_ff + 1'b1;
               ram_raddr = addr_ff + 1'b1;
               state_in  = B_DREAD;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      factor_ff <= factor_in;
      rsp_ff    <= rsp_in;
      f_ff      <= f_in;
      v_ff      <= v_in;
      t_ff      <= t_in;
      prod_ff   <= prod_in;
   end

   assign clearing  = (state_ff == B_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* rtl/lvf_checker.sv */
module lvf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_push,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic               rsp_hit,
   input logic signed [31:0] rsp_field_x,
   input logic signed [31:0] rsp_field_y,
   input logic signed [31:0] rsp_field_z,
   input logic signed [31:0] rsp_vel_x
);

   // cell ram clearing pass follows every reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_full)
      else $error("request side open right after reset");

   // front end stays busy on an accepted beat, so back to back beats are refused
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> req_full)
      else $error("request accepted on back to back cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_hit) && $stable(rsp_field_x) && $stable(rsp_vel_x)))
      else $error("stalled response changed");

   // misses and damp beats carry a zero field
   a_miss_zero_field: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_hit) |->
         (rsp_field_x == 32'sd0 && rsp_field_y == 32'sd0 && rsp_field_z == 32'sd0))
      else $error("nonzero field on a response without hit");

endmodule

bind lattice_vector_field_engine lvf_checker u_lvf_checker (.*);

/* tb/sv/lvf_field_checker.sv */
`timescale 1ns / 1ps

module lvf_field_checker #(
   parameter int GRID_SIDE = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic [17:0]        req_time_step,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  logic               rsp_hit,
   input  logic signed [31:0] rsp_field_x,
   input  logic signed [31:0] rsp_field_y,
   input  logic signed [31:0] rsp_field_z,
   input  logic signed [31:0] rsp_vel_x,
   input  logic signed [31:0] rsp_vel_y,
   input  logic signed [31:0] rsp_vel_z,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output int                 fail_count,
   output int                 waiting
);
   import lvf_pkg::*;

   localparam int CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;

   logic signed [DATA_W-1:0] lattice [CELLS][3];
   logic [SCALE_W-1:0]       scale_cfg;
   logic signed [DATA_W-1:0] coupling_cfg;
   rsp_type                  cell_results_q [$];

   function automatic logic signed [DATA_W-1:0] clamp_word(input longint v);
      logic signed [DATA_W-1:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // q16.16 product, floor division then clamp
   function automatic logic signed [DATA_W-1:0] fix_mul(input longint a, input longint b);
      longint p;
      p = a * b;
      return clamp_word(p >>> 16);
   endfunction

   // q32.32 position times scale, truncated toward zero
   function automatic longint cell_coord(input logic signed [DATA_W-1:0] pos);
      longint p;
      longint c;
      p = longint'(pos) * longint'(scale_cfg);
      if (p >= 0) begin
         c = p >>> 32;
      end else begin
         c = -((-p) >>> 32);
      end
      return c;
   endfunction

   function automatic rsp_type apply_cell_op(input logic [1:0]               mode,
                                             input logic signed [DATA_W-1:0] pos_x,
                                             input logic signed [DATA_W-1:0] pos_y,
                                             input logic signed [DATA_W-1:0] pos_z,
                                             input logic signed [DATA_W-1:0] vec_x,
                                             input logic signed [DATA_W-1:0] vec_y,
                                             input logic signed [DATA_W-1:0] vec_z,
                                             input logic [DT_W-1:0]          time_step);
      rsp_type                  r;
      longint                   idx;
      longint                   dt;
      longint                   factor;
      logic signed [DATA_W-1:0] vin [3];
      logic signed [DATA_W-1:0] fld [3];
      logic signed [DATA_W-1:0] vel [3];
      int                       i;
      int                       j;
      r = '0;
      dt = longint'(time_step);
      vin[0] = vec_x;
      vin[1] = vec_y;
      vin[2] = vec_z;
      for (j = 0; j < 3; j++) begin
         fld[j] = '0;
         vel[j] = '0;
      end
      if (mode == MODE_DAMP) begin
         // factor (2 - dt) / 2 goes negative for dt above 2.0
         factor = longint'(DAMP_ONE) - dt;
         for (i = 0; i < CELLS; i++) begin
            for (j = 0; j < 3; j++) begin
               lattice[i][j] = clamp_word((longint'(lattice[i][j]) * factor) >>> 17);
            end
         end
      end else begin
         // only the combined index is checked, so stray coordinates can alias a cell
         idx = cell_coord(pos_x) + cell_coord(pos_y) * GRID_SIDE
             + cell_coord(pos_z) * GRID_SIDE * GRID_SIDE;
         if (idx >= 0 && idx < CELLS) begin
            r.hit = 1'b1;
            for (j = 0; j < 3; j++) begin
               fld[j] = lattice[idx][j];
               if (mode == MODE_ADD) begin
                  fld[j] = clamp_word(longint'(fld[j]) + longint'(vin[j]));
               end else if (mode == MODE_INTERACT) begin
                  vel[j] = clamp_word(longint'(vin[j]) + longint'(fix_mul(fld[j], dt)));
                  fld[j] = clamp_word(longint'(fld[j])
                                      + longint'(fix_mul(fix_mul(vel[j], dt), coupling_cfg)));
               end
               lattice[idx][j] = fld[j];
            end
         end else if (mode == MODE_INTERACT) begin
            // a missed particle keeps its velocity
            for (j = 0; j < 3; j++) begin
               vel[j] = vin[j];
            end
         end
      end
      r.field_x = fld[0];
      r.field_y = fld[1];
      r.field_z = fld[2];
      r.vel_x   = vel[0];
      r.vel_y   = vel[1];
      r.vel_z   = vel[2];
      return r;
   endfunction

   task automatic compare_word(input string what, input logic [31:0] got,
                               input logic [31:0] want);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      int      i;
      int      j;
      if (reset) begin
         for (i = 0; i < CELLS; i++) begin
            for (j = 0; j < 3; j++) begin
               lattice[i][j] = '0;
            end
         end
         scale_cfg = CELL_SCALE_RESET;
         coupling_cfg = '0;
         cell_results_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_CELL_SCALE) begin
               scale_cfg = csr_wdata[SCALE_W-1:0];
            end else if (csr_index == CSR_COUPLING) begin
               coupling_cfg = csr_wdata;
            end
         end
         if (req_push && !req_full) begin
            cell_results_q.push_back(apply_cell_op(req_mode, req_pos_x, req_pos_y, req_pos_z,
                                                   req_vec_x, req_vec_y, req_vec_z,
                                                   req_time_step));
         end
         if (rsp_pop && !rsp_empty) begin
            if (cell_results_q.size() == 0) begin
               $display("%0t: response beat with none expected, actual hit %b field %h %h %h vel %h %h %h",
                        $time, rsp_hit, rsp_field_x, rsp_field_y, rsp_field_z,
                        rsp_vel_x, rsp_vel_y, rsp_vel_z);
               fail_count++;
            end else begin
               want = cell_results_q.pop_front();
               compare_word("hit", 32'(rsp_hit), 32'(want.hit));
               compare_word("field_x", rsp_field_x, want.field_x);
               compare_word("field_y", rsp_field_y, want.field_y);
               compare_word("field_z", rsp_field_z, want.field_z);
               compare_word("vel_x", rsp_vel_x, want.vel_x);
               compare_word("vel_y", rsp_vel_y, want.vel_y);
               compare_word("vel_z", rsp_vel_z, want.vel_z);
            end
         end
      end
      waiting = cell_results_q.size();
   end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import lvf_pkg::*;

   localparam int GRID_SIDE   = 10;
   localparam int STALL_LIMIT = 20000;
   localparam int END_PAUSE   = 100;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 170;
   // one cell pitch at the reset scale of ten cells per world unit
   localparam int CELL_STEP   = 6554;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;
   localparam logic [31:0]          WORD_MAX    = 32'h7FFF_FFFF;
   localparam logic [31:0]          WORD_MIN    = 32'h8000_0000;
   localparam logic [DT_W-1:0]      DT_ONE      = 18'd65536;
   localparam logic [DT_W-1:0]      DT_TWO      = 18'd131072;
   localparam logic [DT_W-1:0]      DT_MAX      = 18'h3FFFF;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [1:0]         req_mode = '0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic signed [31:0] req_vec_x = '0;
   logic signed [31:0] req_vec_y = '0;
   logic signed [31:0] req_vec_z = '0;
   logic [17:0]        req_time_step = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic               rsp_hit;
   logic signed [31:0] rsp_field_x;
   logic signed [31:0] rsp_field_y;
   logic signed [31:0] rsp_field_z;
   logic signed [31:0] rsp_vel_x;
   logic signed [31:0] rsp_vel_y;
   logic signed [31:0] rsp_vel_z;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   int                 fail_count;
   int                 waiting;
   int                 stall_cycles = 0;
   logic               steady = 1'b0;
   logic [SCALE_W-1:0] cur_scale = CELL_SCALE_RESET;

   lattice_vector_field_engine #(
      .GRID_SIDE(GRID_SIDE)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_mode(req_mode),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .req_vec_x(req_vec_x),
      .req_vec_y(req_vec_y),
      .req_vec_z(req_vec_z),
      .req_time_step(req_time_step),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_hit(rsp_hit),
      .rsp_field_x(rsp_field_x),
      .rsp_field_y(rsp_field_y),
      .rsp_field_z(rsp_field_z),
      .rsp_vel_x(rsp_vel_x),
      .rsp_vel_y(rsp_vel_y),
      .rsp_vel_z(rsp_vel_z),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   lvf_field_checker #(
      .GRID_SIDE(GRID_SIDE)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_mode(req_mode),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .req_vec_x(req_vec_x),
      .req_vec_y(req_vec_y),
      .req_vec_z(req_vec_z),
      .req_time_step(req_time_step),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_hit(rsp_hit),
      .rsp_field_x(rsp_field_x),
      .rsp_field_y(rsp_field_y),
      .rsp_field_z(rsp_field_z),
      .rsp_vel_x(rsp_vel_x),
      .rsp_vel_y(rsp_vel_y),
      .rsp_vel_z(rsp_vel_z),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .waiting(waiting)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_pop = !reset && (steady || $urandom_range(0, 99) >= 18);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [31:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_push = 1'b0;
      while (waiting != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic send(input mode_type mode, input logic [31:0] px, input logic [31:0] py,
                       input logic [31:0] pz, input logic [31:0] vx, input logic [31:0] vy,
                       input logic [31:0] vz, input logic [DT_W-1:0] dt);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 18) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push = 1'b1;
      req_mode = mode;
      req_pos_x = px;
      req_pos_y = py;
      req_pos_z = pz;
      req_vec_x = vx;
      req_vec_y = vy;
      req_vec_z = vz;
      req_time_step = dt;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
   endtask

   // world position that lands on cell coordinate c at the given scale
   function automatic logic [31:0] pos_for_coord(input int c, input logic [SCALE_W-1:0] scale);
      longint      mag;
      longint      q;
      logic [31:0] r;
      if (scale == '0) begin
         r = $urandom;
      end else begin
         mag = (longint'(c < 0 ? -c : c) << 32)
             + longint'($urandom_range(32'(scale), 32'hFFFF_FFFF));
         q = mag / longint'(scale);
         if (q > 64'sd2147483647) begin
            // coordinate out of reach at this scale
            r = $urandom;
         end else if (c < 0) begin
            r = 32'(-q);
         end else begin
            r = 32'(q);
         end
      end
      return r;
   endfunction

   function automatic int rand_coord();
      int pick;
      int c;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         c = $urandom_range(0, 2);
      end else if (pick < 88) begin
         c = $urandom_range(0, GRID_SIDE - 1);
      end else begin
         c = int'($urandom_range(0, GRID_SIDE + 3)) - 2;
      end
      return c;
   endfunction

   function automatic logic [31:0] rand_word();
      logic [31:0] w;
      case ($urandom_range(0, 9))
         0: w = WORD_MAX;
         1: w = WORD_MIN;
         2, 3, 4: w = $urandom;
         default: w = 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
      endcase
      return w;
   endfunction

   function automatic logic [DT_W-1:0] rand_step();
      logic [DT_W-1:0] dt;
      case ($urandom_range(0, 9))
         0: dt = '0;
         1: dt = DT_TWO;
         2: dt = DT_MAX;
         3, 4: dt = DT_W'($urandom);
         default: dt = DT_W'($urandom_range(0, 32768));
      endcase
      return dt;
   endfunction

   task automatic send_random();
      mode_type    mode;
      int          pick;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         mode = MODE_READ;
      end else if (pick < 60) begin
         mode = MODE_ADD;
      end else if (pick < 96) begin
         mode = MODE_INTERACT;
      end else begin
         mode = MODE_DAMP;
      end
      if ($urandom_range(0, 99) < 15) begin
         px = $urandom;
         py = $urandom;
         pz = $urandom;
      end else begin
         px = pos_for_coord(rand_coord(), cur_scale);
         py = pos_for_coord(rand_coord(), cur_scale);
         pz = pos_for_coord(rand_coord(), cur_scale);
      end
      send(mode, px, py, pz, rand_word(), rand_word(), rand_word(), rand_step());
   endtask

   initial begin
      logic [31:0] scale_word [PHASES];
      logic [31:0] coupling_word [PHASES];
      int          ph;
      int          n;

      scale_word[0] = 32'd655360;
      scale_word[1] = 32'd65536;
      scale_word[2] = WORD_MAX;
      scale_word[3] = 32'd0;
      scale_word[4] = 32'd1;
      scale_word[5] = 32'h8000_0000 | 32'd327680;
      scale_word[6] = $urandom_range(1000, 32'h7FFF_FFFF);
      scale_word[7] = 32'(CELL_SCALE_RESET);
      coupling_word[0] = 32'h0001_0000;
      coupling_word[1] = WORD_MAX;
      coupling_word[2] = WORD_MIN;
      coupling_word[3] = $urandom;
      coupling_word[4] = 32'hFFFF_0000;
      coupling_word[5] = $urandom;
      coupling_word[6] = 32'($urandom_range(0, 32'h3_0000)) - 32'h1_8000;
      coupling_word[7] = 32'h0000_8000;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset configuration: ten cells per unit, no feedback into the field
      send(MODE_READ, 0, 0, 0, 0, 0, 0, 0);
      send(MODE_ADD, 0, 0, 0, WORD_MAX, WORD_MIN, 1, 0);
      send(MODE_ADD, 0, 0, 0, WORD_MAX, WORD_MIN, 32'hFFFF_FFFF, 0);
      send(MODE_READ, 9 * CELL_STEP, 9 * CELL_STEP, 9 * CELL_STEP, 0, 0, 0, 0);
      send(MODE_ADD, 9 * CELL_STEP, 9 * CELL_STEP, 9 * CELL_STEP, WORD_MIN, WORD_MAX, 12345, 0);
      // x coordinate one past the far face
      send(MODE_READ, 65536, 9 * CELL_STEP, 9 * CELL_STEP, 0, 0, 0, 0);
      send(MODE_ADD, 65536, 9 * CELL_STEP, 9 * CELL_STEP, $urandom, $urandom, $urandom, 0);
      send(MODE_INTERACT, 65536, 9 * CELL_STEP, 9 * CELL_STEP, 32'h1234_5678, WORD_MIN,
           WORD_MAX, DT_ONE);
      // x of -1 with y of 1 aliases cell 9
      send(MODE_ADD, -CELL_STEP, CELL_STEP, 0, 65536, 32'hFFFF_0000, 3, 0);
      send(MODE_READ, 9 * CELL_STEP, 0, 0, 0, 0, 0, 0);
      send(MODE_READ, -CELL_STEP, 0, 0, 0, 0, 0, 0);
      send(MODE_READ, WORD_MAX, WORD_MAX, WORD_MAX, 0, 0, 0, 0);
      send(MODE_READ, WORD_MIN, WORD_MIN, WORD_MIN, 0, 0, 0, 0);
      send(MODE_READ, WORD_MAX, WORD_MIN, 0, 0, 0, 0, 0);
      send(MODE_INTERACT, 0, 0, 0, 1, 2, 3, 0);
      send(MODE_INTERACT, 9 * CELL_STEP, 0, 0, WORD_MAX, WORD_MIN, 0, DT_TWO);
      send(MODE_INTERACT, 9 * CELL_STEP, 9 * CELL_STEP, 9 * CELL_STEP, 0, 0, 65536, DT_MAX);
      send(MODE_DAMP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, DT_ONE);
      send(MODE_DAMP, 0, 0, 0, 0, 0, 0, 0);
      // damp factor just above -1
      send(MODE_DAMP, 0, 0, 0, 0, 0, 0, DT_MAX);
      send(MODE_READ, 0, 0, 0, 0, 0, 0, 0);
      send(MODE_READ, 9 * CELL_STEP, 9 * CELL_STEP, 9 * CELL_STEP, 0, 0, 0, 0);

      for (ph = 0; ph < PHASES; ph++) begin
         drain();
         write_reg(CSR_CELL_SCALE, scale_word[ph]);
         write_reg(CSR_COUPLING, coupling_word[ph]);
         cur_scale = scale_word[ph][SCALE_W-1:0];
         if (ph == 5) begin
            write_reg(CSR_SPARE_2, $urandom);
            write_reg(CSR_SPARE_3, $urandom);
         end
         steady = (ph == 2);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 4 && n == PHASE_ITEMS / 2) begin
               drain();
            end
            send_random();
         end
      end
      steady = 1'b0;
      drain();
      repeat (END_PAUSE) @(negedge clock);

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
